// ===== rtl/sssd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sssd_pkg;

    localparam int NUM_DIGITS   = 4;
    localparam int NUM_SECTIONS = 5;
    localparam int CELL_LIMIT   = (NUM_DIGITS < NUM_SECTIONS) ? NUM_DIGITS : NUM_SECTIONS;
    localparam bit HAS_IND      = (NUM_DIGITS < NUM_SECTIONS);

    localparam int ACT_W  = 4;
    localparam int CHAR_W = 8;
    localparam int SEC_W  = 3;
    localparam int SEG_W  = 8;

    localparam logic [SEC_W-1:0] DIGITS_C    = SEC_W'(NUM_DIGITS);
    localparam logic [SEC_W-1:0] CELL_LIM_C  = SEC_W'(CELL_LIMIT);
    localparam logic [SEC_W:0]   SECTIONS_C  = (SEC_W + 1)'(NUM_SECTIONS);

    localparam logic [SEG_W-1:0] PT_BIT     = 8'h10;
    localparam logic [SEG_W-1:0] PAT_MINUS  = 8'd128;
    localparam logic [SEG_W-1:0] PAT_UNDER  = 8'd8;
    localparam logic [SEG_W-1:0] PAT_QUEST  = 8'd163;
    localparam logic [SEG_W-1:0] PAT_SLASH  = 8'd162;
    localparam logic [SEG_W-1:0] PAT_STAR   = 8'd195;
    localparam logic [SEG_W-1:0] MARK_COLON = 8'd3;
    localparam logic [SEG_W-1:0] MARK_UPPER = 8'd4;

    typedef enum logic [ACT_W-1:0] {
        ACT_TICK       = 4'd0,
        ACT_CLEAR      = 4'd1,
        ACT_PUT        = 4'd2,
        ACT_POINT_LAST = 4'd3,
        ACT_POINT_ON   = 4'd4,
        ACT_POINT_OFF  = 4'd5,
        ACT_COLON_ON   = 4'd6,
        ACT_COLON_OFF  = 4'd7,
        ACT_UPPER_ON   = 4'd8,
        ACT_UPPER_OFF  = 4'd9,
        ACT_LOAD       = 4'd10
    } action_t;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [CHAR_W-1:0] char_code;
        logic [SEC_W-1:0]  position;
    } item_t;

    typedef struct packed {
        logic              drive_valid;
        logic [SEC_W-1:0]  section;
        logic [SEG_W-1:0]  segments;
        logic              point_line;
        logic [SEC_W-1:0]  cursor;
    } result_t;

    typedef logic [SEG_W-1:0] cell_buf_t [NUM_SECTIONS];

    localparam logic [SEG_W-1:0] ROM_DIGIT [10] = '{
        8'd111, 8'd6, 8'd171, 8'd143, 8'd198, 8'd205, 8'd237, 8'd7, 8'd239, 8'd207
    };
    localparam logic [SEG_W-1:0] ROM_UPPER [26] = '{
        8'd231, 8'd239, 8'd105, 8'd111, 8'd233, 8'd225, 8'd109, 8'd230, 8'd6,
        8'd14, 8'd234, 8'd104, 8'd99, 8'd103, 8'd111, 8'd227, 8'd199, 8'd97,
        8'd205, 8'd232, 8'd110, 8'd110, 8'd108, 8'd15, 8'd198, 8'd171
    };
    localparam logic [SEG_W-1:0] ROM_LOWER [26] = '{
        8'd175, 8'd236, 8'd168, 8'd174, 8'd235, 8'd225, 8'd207, 8'd228, 8'd4,
        8'd15, 8'd234, 8'd104, 8'd164, 8'd164, 8'd172, 8'd227, 8'd119, 8'd160,
        8'd205, 8'd232, 8'd44, 8'd44, 8'd44, 8'd140, 8'd206, 8'd171
    };

    // character rom, unknown codes blank
    function automatic logic [SEG_W-1:0] char_pattern(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] off;
        logic [SEG_W-1:0]  pat;
        off = '0;
        pat = '0;
        if (c >= 8'h61 && c <= 8'h7a)
        begin
            off = c - 8'h61;
            pat = ROM_LOWER[off[4:0]];
        end
        else if (c >= 8'h41 && c <= 8'h5a)
        begin
            off = c - 8'h41;
            pat = ROM_UPPER[off[4:0]];
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            off = c - 8'h30;
            pat = ROM_DIGIT[off[3:0]];
        end
        else if (c == 8'h2d)
            pat = PAT_MINUS;
        else if (c == 8'h5f)
            pat = PAT_UNDER;
        else if (c == 8'h3f)
            pat = PAT_QUEST;
        else if (c == 8'h2f)
            pat = PAT_SLASH;
        else if (c == 8'h2a)
            pat = PAT_STAR;
        return pat;
    endfunction

    // second cell for wide letters
    function automatic logic [SEG_W-1:0] tail_pattern(input logic [CHAR_W-1:0] c);
        logic [SEG_W-1:0] pat;
        case (c)
            8'h4d:   pat = 8'd71;
            8'h6d:   pat = 8'd164;
            8'h57:   pat = 8'd46;
            8'h77:   pat = 8'd44;
            8'h58:   pat = 8'd105;
            8'h78:   pat = 8'd168;
            default: pat = 8'd0;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sssd_cmd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sssd_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [sssd_pkg::ACT_W-1:0]   action;
    logic [sssd_pkg::CHAR_W-1:0]  char_code;
    logic [sssd_pkg::SEC_W-1:0]   position;

    modport source (output valid, output action, output char_code, output position,
                    input ready);
    modport sink (input valid, input action, input char_code, input position,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/sssd_drv_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sssd_drv_if;
    logic                        valid;
    logic                        ready;
    logic                        drive_valid;
    logic [sssd_pkg::SEC_W-1:0]  section;
    logic [sssd_pkg::SEG_W-1:0]  segments;
    logic                        point_line;
    logic [sssd_pkg::SEC_W-1:0]  cursor;

    modport source (output valid, output drive_valid, output section, output segments,
                    output point_line, output cursor, input ready);
    modport sink (input valid, input drive_valid, input section, input segments,
                  input point_line, input cursor, output ready);
endinterface

`default_nettype wire

// ===== rtl/seven_segment_text_display_scanner_top.sv =====
// path: a command is held in the input register, and its result in the result register
// throughput: one transaction per cycle while the drive side is ready; the core state update sits
// between the input register and the result register
// reset: buffers, write cursor, scan index and pending load clear at once; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module seven_segment_text_display_scanner_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sssd_cmd_if.sink   cmd,
    sssd_drv_if.source drv
);

    // command transaction as a packed item
    sssd_pkg::item_t   in_item;
    sssd_pkg::item_t   item;
    logic              item_valid;
    logic              take;
    logic              out_valid;
    sssd_pkg::result_t result;

    assign in_item.action    = cmd.action;
    assign in_item.char_code = cmd.char_code;
    assign in_item.position  = cmd.position;

    // input register: frees the command side while the core works
    sssd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cmd.valid),
        .in_ready   (cmd.ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .take       (take)
    );

    // display state, character rom and the result register
    sssd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .out_valid  (out_valid),
        .out_ready  (drv.ready),
        .result     (result)
    );

    // drive side
    assign drv.valid       = out_valid;
    assign drv.drive_valid = result.drive_valid;
    assign drv.section     = result.section;
    assign drv.segments    = result.segments;
    assign drv.point_line  = result.point_line;
    assign drv.cursor      = result.cursor;

    // cursor never runs past the last digit cell
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        drv.valid |-> (drv.cursor <= sssd_pkg::DIGITS_C))
        else $error("write cursor beyond digit cells");

    // command results carry no drive
    a_idle_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (drv.valid && !drv.drive_valid) |->
            (drv.segments == '0 && drv.section == '0 && !drv.point_line))
        else $error("non-tick result carries a drive");

    // scanned section is a real one and the point line follows the pattern
    a_scan_section: assert property (@(posedge clk) disable iff (!rst_n)
        (drv.valid && drv.drive_valid) |->
            ({1'b0, drv.section} < sssd_pkg::SECTIONS_C && drv.point_line == drv.segments[4]))
        else $error("bad scan drive");

    // a held command is not taken when the result side is full and stalled
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !drv.ready) |-> !take)
        else $error("core advanced into a stalled result");

endmodule

`default_nettype wire

// ===== rtl/sssd_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sssd_in_stage (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire sssd_pkg::item_t in_item,
    output logic                 item_valid,
    output sssd_pkg::item_t      item,
    input  wire logic            take
);

    logic            valid_reg;
    logic            valid_next;
    sssd_pkg::item_t item_reg;

    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_item;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== rtl/sssd_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sssd_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    input  wire sssd_pkg::item_t item,
    output logic                 take,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output sssd_pkg::result_t    result
);

    sssd_pkg::cell_buf_t back_reg, back_next;
    sssd_pkg::cell_buf_t front_reg, front_next;
    logic [sssd_pkg::SEC_W-1:0] cursor_reg, cursor_next;
    logic [sssd_pkg::SEC_W-1:0] scan_reg, scan_next;
    logic                       pending_reg, pending_next;
    logic                       out_valid_reg, out_valid_next;
    sssd_pkg::result_t          result_reg, res_next;

    logic [sssd_pkg::SEC_W-1:0] idx;
    logic [sssd_pkg::SEC_W:0]   scan_inc;
    logic [sssd_pkg::SEC_W-1:0] cur1;
    logic [sssd_pkg::SEG_W-1:0] pat;
    logic [sssd_pkg::SEG_W-1:0] tail;

    assign take = item_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        back_next    = back_reg;
        front_next   = front_reg;
        cursor_next  = cursor_reg;
        scan_next    = scan_reg;
        pending_next = pending_reg;
        res_next     = '0;
        idx          = '0;
        scan_inc     = '0;
        cur1         = cursor_reg + 1'b1;
        pat          = sssd_pkg::char_pattern(item.char_code);
        tail         = sssd_pkg::tail_pattern(item.char_code);

        case (sssd_pkg::action_t'(item.action))
            sssd_pkg::ACT_TICK:
            begin
                idx = ({1'b0, scan_reg} >= sssd_pkg::SECTIONS_C) ? '0 : scan_reg;
                res_next.drive_valid = 1'b1;
                res_next.section     = idx;
                res_next.segments    = front_reg[idx];
                res_next.point_line  = front_reg[idx][4];
                scan_inc = {1'b0, idx} + 1'b1;
                if (scan_inc >= sssd_pkg::SECTIONS_C)
                begin
                    // frame end: take the new picture if one is waiting
                    scan_next = '0;
                    if (pending_reg)
                    begin
                        front_next   = back_reg;
                        pending_next = 1'b0;
                    end
                end
                else
                    scan_next = scan_inc[sssd_pkg::SEC_W-1:0];
            end
            sssd_pkg::ACT_CLEAR:
            begin
                for (int i = 0; i < sssd_pkg::NUM_SECTIONS; i++)
                    back_next[i] = '0;
                cursor_next = '0;
            end
            sssd_pkg::ACT_PUT:
            begin
                if (cursor_reg < sssd_pkg::DIGITS_C && cursor_reg < sssd_pkg::CELL_LIM_C)
                begin
                    for (int i = 0; i < sssd_pkg::NUM_SECTIONS; i++)
                    begin
                        if (sssd_pkg::SEC_W'(i) == cursor_reg)
                            back_next[i] = (back_reg[i] & sssd_pkg::PT_BIT) | pat;
                        if (tail != '0 && cur1 < sssd_pkg::CELL_LIM_C
                            && sssd_pkg::SEC_W'(i) == cur1)
                            back_next[i] = (back_reg[i] & sssd_pkg::PT_BIT) | tail;
                    end
                    if (tail != '0 && cur1 < sssd_pkg::CELL_LIM_C)
                        cursor_next = cur1 + 1'b1;
                    else
                        cursor_next = cur1;
                end
            end
            sssd_pkg::ACT_POINT_LAST:
            begin
                if (cursor_reg != '0 && cursor_reg <= sssd_pkg::CELL_LIM_C)
                begin
                    for (int i = 0; i < sssd_pkg::NUM_SECTIONS; i++)
                        if (sssd_pkg::SEC_W'(i + 1) == cursor_reg)
                            back_next[i] = back_reg[i] | sssd_pkg::PT_BIT;
                end
            end
            sssd_pkg::ACT_POINT_ON:
            begin
                for (int i = 0; i < sssd_pkg::NUM_SECTIONS; i++)
                    if (sssd_pkg::SEC_W'(i) == item.position)
                        back_next[i] = back_reg[i] | sssd_pkg::PT_BIT;
            end
            sssd_pkg::ACT_POINT_OFF:
            begin
                for (int i = 0; i < sssd_pkg::NUM_SECTIONS; i++)
                    if (sssd_pkg::SEC_W'(i) == item.position)
                        back_next[i] = back_reg[i] & ~sssd_pkg::PT_BIT;
            end
            sssd_pkg::ACT_COLON_ON:
            begin
                for (int i = 0; i < sssd_pkg::NUM_SECTIONS; i++)
                    if (sssd_pkg::HAS_IND && i == sssd_pkg::NUM_DIGITS)
                        back_next[i] = back_reg[i] | sssd_pkg::MARK_COLON;
            end
            sssd_pkg::ACT_COLON_OFF:
            begin
                for (int i = 0; i < sssd_pkg::NUM_SECTIONS; i++)
                    if (sssd_pkg::HAS_IND && i == sssd_pkg::NUM_DIGITS)
                        back_next[i] = back_reg[i] & ~sssd_pkg::MARK_COLON;
            end
            sssd_pkg::ACT_UPPER_ON:
            begin
                for (int i = 0; i < sssd_pkg::NUM_SECTIONS; i++)
                    if (sssd_pkg::HAS_IND && i == sssd_pkg::NUM_DIGITS)
                        back_next[i] = back_reg[i] | sssd_pkg::MARK_UPPER;
            end
            sssd_pkg::ACT_UPPER_OFF:
            begin
                for (int i = 0; i < sssd_pkg::NUM_SECTIONS; i++)
                    if (sssd_pkg::HAS_IND && i == sssd_pkg::NUM_DIGITS)
                        back_next[i] = back_reg[i] & ~sssd_pkg::MARK_UPPER;
            end
            sssd_pkg::ACT_LOAD:
                pending_next = 1'b1;
            default:
            begin
                // unused codes leave everything as it is
            end
        endcase

        res_next.cursor = cursor_next;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sssd_pkg::NUM_SECTIONS; i++)
            begin
                back_reg[i]  <= '0;
                front_reg[i] <= '0;
            end
            cursor_reg    <= '0;
            scan_reg      <= '0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                back_reg    <= back_next;
                front_reg   <= front_next;
                cursor_reg  <= cursor_next;
                scan_reg    <= scan_next;
                pending_reg <= pending_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            result_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire
